>>> hw/rtl/imu_dr_pkg.sv
// shared types and constants of the imu dead reckoning integrator
package imu_dr_pkg;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_QMUL  = 12'b0000_0000_0010,
    S_RMAT  = 12'b0000_0000_0100,
    S_PREP  = 12'b0000_0000_1000,
    S_RND   = 12'b0000_0001_0000,
    S_MLO   = 12'b0000_0010_0000,
    S_MHI   = 12'b0000_0100_0000,
    S_SUM   = 12'b0000_1000_0000,
    S_DIV   = 12'b0001_0000_0000,
    S_DSUB  = 12'b0010_0000_0000,
    S_APPLY = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  localparam logic [1:0] REG_FORWARD_SPEED = 2'd0;
  localparam logic [1:0] REG_SYNC_POINT_X  = 2'd1;
  localparam logic [1:0] REG_SYNC_POINT_Y  = 2'd2;

  localparam logic [15:0] FORWARD_SPEED_RESET = 16'd9830;
  localparam int USEC_PER_SEC = 1000000;
  localparam logic [2:0] SYNC_PERIOD_END = 3'd5;
  // one million is 2^6 * 15625; 16 bit digits divided by reciprocal multiply
  localparam int DIV_PRE_SHIFT = 6;
  localparam logic [13:0] DIV_ODD = 14'd15625;
  localparam logic [30:0] DIV_RECIP = 31'd1125899907;
  localparam int DIV_RECIP_SHIFT = 44;
  localparam int DIV_DIGITS = 6;
  localparam int OUT_WIDTH = 48;

endpackage

>>> hw/rtl/imu_dead_reckoning_integrator.sv
// top level of the imu dead reckoning integrator: sequencer around one shared multiplier
//
// An IMU sample (tuser 0) is taken when s_tready is high; the first sample after reset only
// latches its timestamp and clears the positions, and every later sample gives one output item
// with the three position estimates. A sync event (tuser 1) and the first sample finish in the
// cycle they are accepted. A full sample keeps s_tready low until it is done, so a new sample
// is not taken before the last one is through: the nine quaternion products, the rotation
// matrix, then seven time integrations (none, one or three products, a 64 by 32 product in
// two halves and a six digit reciprocal division by one million), and the load of the output
// register. A finished item waits in the output register and does not hold off the next
// input, but a sample that finishes while the previous item still waits holds in its last
// step until m_tready. Configuration may be written at any time the block is idle.
module imu_dead_reckoning_integrator #(
  parameter int POS_WIDTH = 48,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // timestamp_us, quat_x, quat_y, quat_z, quat_w, accel_x, accel_y, accel_z
  input  logic [143:0] s_tdata,
  // action
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // synced_x, synced_y, synced_z, speed_x, speed_y, speed_z,
  // accel_pos_x, accel_pos_y, accel_pos_z
  output logic [431:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic [2:0] JOB_ACC0 = 3'd3;
  localparam logic [2:0] JOB_POS0 = 3'd5;
  localparam logic [2:0] JOB_LAST = 3'd6;
  localparam logic signed [65:0] PMAX = (66'sd1 <<< (POS_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] PMIN = -PMAX - 66'sd1;
  localparam logic signed [63:0] ONE = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (QUAT_FRAC_BITS - 1);
  localparam int OW = imu_dr_pkg::OUT_WIDTH;

  function automatic logic signed [POS_WIDTH-1:0] sat_pos(
    input logic signed [POS_WIDTH-1:0] p,
    input logic signed [63:0] d
  );
    logic signed [65:0] s;
    s = 66'(p) + 66'(d);
    if (s > PMAX) s = PMAX;
    else if (s < PMIN) s = PMIN;
    return s[POS_WIDTH-1:0];
  endfunction

  function automatic logic signed [63:0] rnd_q(input logic signed [63:0] v);
    return (v + HALF) >>> QUAT_FRAC_BITS;
  endfunction

  function automatic logic [OW-1:0] ext_out(input logic signed [POS_WIDTH-1:0] p);
    logic signed [63:0] e;
    e = 64'(p);
    return e[OW-1:0];
  endfunction

  imu_dr_pkg::state_t state;
  logic [6:0]  cnt;
  logic [2:0]  job;
  logic        first;
  logic [31:0] last_time;
  logic [31:0] dt;
  logic [2:0]  sync_count;
  logic [2:0]  sync_next;
  logic [15:0] forward_speed;
  logic signed [31:0] sync_x;
  logic signed [31:0] sync_y;

  logic signed [15:0] qin [0:3];
  logic signed [15:0] uin [0:2];
  logic signed [31:0] qp [0:8];
  logic signed [32:0] rm [0:6];
  logic signed [63:0] rcalc [0:6];
  logic signed [49:0] acc;
  logic signed [63:0] iv;
  logic [63:0] mag;
  logic [63:0] pl;
  logic [63:0] ph;
  logic [95:0] num;
  logic [13:0] rem;
  logic [29:0] dcur;
  logic [15:0] dq;
  logic [29:0] dback;
  logic signed [63:0] dval;
  logic [63:0] dmag;

  logic signed [POS_WIDTH-1:0] syn [0:2];
  logic signed [POS_WIDTH-1:0] spd [0:2];
  logic signed [POS_WIDTH-1:0] vel [0:1];
  logic signed [POS_WIDTH-1:0] pa [0:1];
  logic [431:0] od;
  logic         ov;

  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] mp;
  logic [2:0] ri;
  logic       jv;
  logic signed [63:0] acc_rnd;

  assign s_tready = (state == imu_dr_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid = ov;
  assign m_tdata = od;

  // jobs 3 and 5 use axis x, jobs 4 and 6 axis y
  assign jv = ~job[0];
  assign mag = iv[63] ? 64'(-iv) : iv;
  assign mp = ma * mb;
  assign dcur = {rem, num[95:80]};
  assign dq = pl[imu_dr_pkg::DIV_RECIP_SHIFT +: 16];
  assign dback = 30'(dq) * 30'(imu_dr_pkg::DIV_ODD);
  assign dmag = num[63:0];
  assign acc_rnd = rnd_q(64'(acc));
  assign sync_next = sync_count + 3'd1;

  always_comb begin
    if (|num[95:63]) begin
      dval = iv[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      dval = iv[63] ? -$signed(dmag) : $signed(dmag);
    end
  end

  always_comb begin
    if (job < JOB_ACC0) begin
      ri = 3'(job[1:0]) * 3'd3;
    end else begin
      ri = (jv ? 3'd3 : 3'd0) + {1'b0, cnt[1:0]};
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      imu_dr_pkg::S_QMUL: begin
        case (cnt[3:0])
          4'd0: begin ma = 33'(qin[0]); mb = 33'(qin[0]); end
          4'd1: begin ma = 33'(qin[1]); mb = 33'(qin[1]); end
          4'd2: begin ma = 33'(qin[2]); mb = 33'(qin[2]); end
          4'd3: begin ma = 33'(qin[0]); mb = 33'(qin[1]); end
          4'd4: begin ma = 33'(qin[0]); mb = 33'(qin[2]); end
          4'd5: begin ma = 33'(qin[1]); mb = 33'(qin[2]); end
          4'd6: begin ma = 33'(qin[0]); mb = 33'(qin[3]); end
          4'd7: begin ma = 33'(qin[1]); mb = 33'(qin[3]); end
          default: begin ma = 33'(qin[2]); mb = 33'(qin[3]); end
        endcase
      end
      imu_dr_pkg::S_PREP: begin
        ma = rm[ri];
        if (job < JOB_ACC0) mb = {17'd0, forward_speed};
        else mb = 33'(uin[cnt[1:0]]);
      end
      imu_dr_pkg::S_MLO: begin
        ma = {1'b0, mag[31:0]};
        mb = {1'b0, dt};
      end
      imu_dr_pkg::S_MHI: begin
        ma = {1'b0, mag[63:32]};
        mb = {1'b0, dt};
      end
      imu_dr_pkg::S_DIV: begin
        ma = {3'd0, dcur};
        mb = {2'd0, imu_dr_pkg::DIV_RECIP};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // rotation matrix rows x and y and entry zx, from xx yy zz xy xz yz xw yw zw
  always_comb begin
    rcalc[0] = ONE - 64'sd2 * (64'(qp[1]) + 64'(qp[2]));
    rcalc[1] = 64'sd2 * (64'(qp[3]) - 64'(qp[8]));
    rcalc[2] = 64'sd2 * (64'(qp[4]) + 64'(qp[7]));
    rcalc[3] = 64'sd2 * (64'(qp[3]) + 64'(qp[8]));
    rcalc[4] = ONE - 64'sd2 * (64'(qp[0]) + 64'(qp[2]));
    rcalc[5] = 64'sd2 * (64'(qp[5]) - 64'(qp[6]));
    rcalc[6] = 64'sd2 * (64'(qp[4]) - 64'(qp[7]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imu_dr_pkg::S_IDLE;
      cnt <= '0;
      job <= '0;
      first <= 1'b1;
      last_time <= '0;
      sync_count <= '0;
      forward_speed <= imu_dr_pkg::FORWARD_SPEED_RESET;
      sync_x <= '0;
      sync_y <= '0;
      ov <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        syn[i] <= '0;
        spd[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        vel[i] <= '0;
        pa[i] <= '0;
      end
    end else begin
      if (ov && m_tready && state != imu_dr_pkg::S_DONE) ov <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          imu_dr_pkg::REG_FORWARD_SPEED: forward_speed <= cfg_data[15:0];
          imu_dr_pkg::REG_SYNC_POINT_X: sync_x <= cfg_data;
          imu_dr_pkg::REG_SYNC_POINT_Y: sync_y <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        imu_dr_pkg::S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              if (sync_next == imu_dr_pkg::SYNC_PERIOD_END) begin
                syn[0] <= POS_WIDTH'(sync_x);
                syn[1] <= POS_WIDTH'(sync_y);
                syn[2] <= '0;
                sync_count <= 3'd1;
              end else begin
                sync_count <= sync_next;
              end
            end else if (first) begin
              last_time <= s_tdata[31:0];
              first <= 1'b0;
              for (int i = 0; i < 3; i++) begin
                syn[i] <= '0;
                spd[i] <= '0;
              end
              for (int i = 0; i < 2; i++) pa[i] <= '0;
            end else begin
              dt <= s_tdata[31:0] - last_time;
              last_time <= s_tdata[31:0];
              for (int i = 0; i < 4; i++) qin[i] <= s_tdata[32 + 16*i +: 16];
              for (int i = 0; i < 3; i++) uin[i] <= s_tdata[96 + 16*i +: 16];
              cnt <= '0;
              state <= imu_dr_pkg::S_QMUL;
            end
          end
        end
        imu_dr_pkg::S_QMUL: begin
          qp[cnt[3:0]] <= mp[31:0];
          if (cnt == 7'd8) state <= imu_dr_pkg::S_RMAT;
          else cnt <= cnt + 7'd1;
        end
        imu_dr_pkg::S_RMAT: begin
          for (int i = 0; i < 7; i++) begin
            rm[i] <= 33'(rnd_q(rcalc[i]));
          end
          job <= '0;
          cnt <= '0;
          state <= imu_dr_pkg::S_PREP;
        end
        imu_dr_pkg::S_PREP: begin
          if (job >= JOB_POS0) begin
            iv <= 64'(vel[jv]);
            state <= imu_dr_pkg::S_MLO;
          end else begin
            acc <= (cnt == 7'd0) ? 50'(mp) : acc + 50'(mp);
            if ((job < JOB_ACC0) || (cnt == 7'd2)) state <= imu_dr_pkg::S_RND;
            else cnt <= cnt + 7'd1;
          end
        end
        imu_dr_pkg::S_RND: begin
          iv <= (job < JOB_ACC0) ? acc_rnd : (acc_rnd <<< 8);
          state <= imu_dr_pkg::S_MLO;
        end
        imu_dr_pkg::S_MLO: begin
          pl <= mp[63:0];
          state <= imu_dr_pkg::S_MHI;
        end
        imu_dr_pkg::S_MHI: begin
          ph <= mp[63:0];
          state <= imu_dr_pkg::S_SUM;
        end
        imu_dr_pkg::S_SUM: begin
          num <= (96'(pl) + {ph, 32'd0} + 96'(imu_dr_pkg::USEC_PER_SEC / 2))
                 >> imu_dr_pkg::DIV_PRE_SHIFT;
          rem <= '0;
          cnt <= '0;
          state <= imu_dr_pkg::S_DIV;
        end
        imu_dr_pkg::S_DIV: begin
          pl <= mp[63:0];
          state <= imu_dr_pkg::S_DSUB;
        end
        imu_dr_pkg::S_DSUB: begin
          rem <= 14'(dcur - dback);
          num <= {num[79:0], dq};
          if (cnt == 7'(imu_dr_pkg::DIV_DIGITS - 1)) begin
            state <= imu_dr_pkg::S_APPLY;
          end else begin
            cnt <= cnt + 7'd1;
            state <= imu_dr_pkg::S_DIV;
          end
        end
        imu_dr_pkg::S_APPLY: begin
          if (job < JOB_ACC0) begin
            syn[job[1:0]] <= sat_pos(syn[job[1:0]], dval);
            spd[job[1:0]] <= sat_pos(spd[job[1:0]], dval);
          end else if (job < JOB_POS0) begin
            vel[jv] <= sat_pos(vel[jv], dval);
          end else begin
            pa[jv] <= sat_pos(pa[jv], dval);
          end
          cnt <= '0;
          if (job == JOB_LAST) begin
            state <= imu_dr_pkg::S_DONE;
          end else begin
            job <= job + 3'd1;
            state <= imu_dr_pkg::S_PREP;
          end
        end
        imu_dr_pkg::S_DONE: begin
          if (!ov || m_tready) begin
            od <= {{OW{1'b0}}, ext_out(pa[1]), ext_out(pa[0]),
                   ext_out(spd[2]), ext_out(spd[1]), ext_out(spd[0]),
                   ext_out(syn[2]), ext_out(syn[1]), ext_out(syn[0])};
            ov <= 1'b1;
            state <= imu_dr_pkg::S_IDLE;
          end
        end
        default: state <= imu_dr_pkg::S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == imu_dr_pkg::S_DSUB && cnt == 7'(imu_dr_pkg::DIV_DIGITS - 1))
      |=> state == imu_dr_pkg::S_APPLY)
    else $error("division did not end in apply");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == imu_dr_pkg::S_DIV || state == imu_dr_pkg::S_DSUB)
      |-> rem < imu_dr_pkg::DIV_ODD)
    else $error("division remainder out of range");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == imu_dr_pkg::S_DONE))
    else $error("output item not from done state");
  a_job_range: assert property (@(posedge clk) disable iff (rst)
    job <= JOB_LAST)
    else $error("job index out of range");
  a_sync_range: assert property (@(posedge clk) disable iff (rst)
    sync_count < imu_dr_pkg::SYNC_PERIOD_END)
    else $error("sync count past period end");
`endif

endmodule
